/* rtl/tilp_pkg.sv */
package tilp_pkg;

  localparam int ArityMax = 16;
  localparam int ArityW = 5;
  localparam int PosW = 4;
  localparam int CountW = 16;
  localparam int MagW = 31;
  localparam int ValueW = 32;

  localparam logic [MagW-1:0] MagMax = 31'h7fff_ffff;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic RegArity = 1'b0;
  localparam logic RegMaxValues = 1'b1;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StMalformed  = 3'd1,
    StOverflow   = 3'd2,
    StTooMany    = 3'd3,
    StIncomplete = 3'd4
  } status_t;

  typedef struct packed {
    logic                inc;
    logic                clr;
    logic [PosW-1:0]     sel;
  } tc_ctrl_t;

endpackage

/* rtl/tilp_tuple_cnt.sv */
module tilp_tuple_cnt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tilp_pkg::tc_ctrl_t            ctrl,
  output logic [tilp_pkg::CountW-1:0]   tuple_count
);

  // one quotient/remainder pair per possible arity, advanced with the value count
  logic [tilp_pkg::CountW-1:0] quot_r   [tilp_pkg::ArityMax];
  logic [tilp_pkg::PosW-1:0]   rem_r    [tilp_pkg::ArityMax];
  logic [tilp_pkg::CountW-1:0] quot_nxt [tilp_pkg::ArityMax];
  logic [tilp_pkg::PosW-1:0]   rem_nxt  [tilp_pkg::ArityMax];

  always_comb begin
    for (int k = 0; k < tilp_pkg::ArityMax; k++) begin
      quot_nxt[k] = quot_r[k];
      rem_nxt[k]  = rem_r[k];
      if (ctrl.inc) begin
        if (rem_r[k] == tilp_pkg::PosW'(k)) begin
          quot_nxt[k] = quot_r[k] + 1'b1;
          rem_nxt[k]  = '0;
        end else begin
          rem_nxt[k]  = rem_r[k] + 1'b1;
        end
      end
    end
  end

  assign tuple_count = quot_nxt[ctrl.sel];

  always_ff @(posedge clk) begin
    for (int k = 0; k < tilp_pkg::ArityMax; k++) begin
      if (!rst_n || ctrl.clr) begin
        quot_r[k] <= '0;
        rem_r[k]  <= '0;
      end else begin
        quot_r[k] <= quot_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

endmodule

/* rtl/tuple_integer_list_parser.sv */
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// input     | in_valid / in_ready        | in_byte, in_is_last, in_end_only
// result    | out_valid / out_ready      | out_value_valid, out_value, out_value_index,
//           |                            | out_done_res, out_status, out_tuple_count
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One byte per cycle while in_ready is high: each request is parsed in the cycle it
// is accepted and its result lands in the output register at that edge.
// in_ready drops only while the output register is full and out_ready is low.
// rst_n is synchronous; it clears the parse state, the output valid and restores
// tuple_arity = 1, max_values = 65535.
module tuple_integer_list_parser (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  input  logic        in_end_only,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_value_valid,
  output logic signed [31:0] out_value,
  output logic [15:0] out_value_index,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [15:0] out_tuple_count,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDrain  = 2'd3
  } phase_t;

  localparam int MagW = tilp_pkg::MagW;
  localparam int CntW = tilp_pkg::CountW;
  localparam int PosW = tilp_pkg::PosW;
  localparam int ArW  = tilp_pkg::ArityW;
  localparam int ValW = tilp_pkg::ValueW;

  // configuration
  logic [ArW-1:0]  arity_r;
  logic [CntW-1:0] maxv_r;

  // parse state
  phase_t          phase_r, phase_nxt;
  logic [MagW-1:0] mag_r, mag_nxt;
  logic            neg_r, neg_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] vcnt_r, vcnt_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic            vv_r;
  logic [ValW-1:0] val_r;
  logic [CntW-1:0] idx_r;
  logic            done_r;
  tilp_pkg::status_t st_r;
  logic [CntW-1:0] tc_r;

  logic in_fire;
  logic cfg_wr;

  // byte stage
  logic            is_digit;
  logic [3:0]      digit;
  logic [MagW+3:0] mag_x10;
  phase_t          ph_i;
  logic [MagW-1:0] mag_i;
  logic            neg_i;
  tilp_pkg::status_t byte_err;
  logic            sep_fin;

  // value finish
  logic [ArW-1:0]  eff_ar;
  logic [ArW-1:0]  fin_t;
  logic [PosW-1:0] fin_pos;
  logic [PosW-1:0] pos_after;
  logic [7:0]      exp_sep;
  logic            closing;
  logic            close_fin;
  logic            fin_req;
  logic            fin_ok;
  tilp_pkg::status_t fin_err;
  tilp_pkg::status_t step_err;
  tilp_pkg::status_t close_st;
  logic [ValW-1:0] fin_value;

  // result of this request
  logic            res_v;
  logic            r_vv;
  logic [ValW-1:0] r_val;
  logic [CntW-1:0] r_idx;
  logic            r_done;
  tilp_pkg::status_t r_st;
  logic [CntW-1:0] r_tc;
  logic            clr;

  tilp_pkg::tc_ctrl_t tc_ctrl;
  logic [CntW-1:0]    tc_count;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_comb begin
    unique case (paddr[2])
      tilp_pkg::RegArity:     prdata = {{(32-ArW){1'b0}}, arity_r};
      tilp_pkg::RegMaxValues: prdata = {{(32-CntW){1'b0}}, maxv_r};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    if (arity_r == '0) begin
      eff_ar = ArW'(1);
    end else if (arity_r > ArW'(tilp_pkg::ArityMax)) begin
      eff_ar = ArW'(tilp_pkg::ArityMax);
    end else begin
      eff_ar = arity_r;
    end
  end

  assign is_digit = (in_byte >= tilp_pkg::ChZero) && (in_byte <= tilp_pkg::ChNine);
  assign digit    = in_byte[3:0];
  assign mag_x10  = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + (MagW+4)'(digit);

  always_comb begin
    ph_i     = phase_r;
    mag_i    = mag_r;
    neg_i    = neg_r;
    byte_err = tilp_pkg::StOk;
    sep_fin  = 1'b0;
    if (!in_end_only) begin
      unique case (phase_r)
        PhStart: begin
          if (in_byte == tilp_pkg::ChMinus) begin
            neg_i = 1'b1;
            ph_i  = PhSign;
          end else if (is_digit) begin
            mag_i = MagW'(digit);
            ph_i  = PhDigits;
          end else begin
            byte_err = tilp_pkg::StMalformed;
          end
        end
        PhSign: begin
          if (is_digit) begin
            mag_i = MagW'(digit);
            ph_i  = PhDigits;
          end else begin
            byte_err = tilp_pkg::StMalformed;
          end
        end
        PhDigits: begin
          if (is_digit) begin
            if (mag_x10 > (MagW+4)'(tilp_pkg::MagMax)) begin
              byte_err = tilp_pkg::StOverflow;
            end else begin
              mag_i = mag_x10[MagW-1:0];
            end
          end else begin
            sep_fin = 1'b1;
          end
        end
        PhDrain: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign fin_t     = {1'b0, pos_r} + 1'b1;
  assign fin_pos   = (fin_t >= eff_ar) ? '0 : fin_t[PosW-1:0];
  assign exp_sep   = (fin_pos != '0) ? tilp_pkg::ChUnder : tilp_pkg::ChComma;
  assign fin_value = neg_i ? (~{1'b0, mag_i} + 1'b1) : {1'b0, mag_i};

  always_comb begin
    if (vcnt_r >= maxv_r) begin
      fin_err = tilp_pkg::StTooMany;
    end else if (sep_fin && (in_byte != exp_sep)) begin
      fin_err = tilp_pkg::StMalformed;
    end else begin
      fin_err = tilp_pkg::StOk;
    end
  end

  always_comb begin
    if (in_end_only) begin
      step_err = tilp_pkg::StOk;
    end else if (byte_err != tilp_pkg::StOk) begin
      step_err = byte_err;
    end else if (sep_fin) begin
      step_err = fin_err;
    end else begin
      step_err = tilp_pkg::StOk;
    end
  end

  assign closing   = in_end_only || in_is_last;
  assign close_fin = closing && (ph_i == PhDigits) && !sep_fin;
  assign fin_req   = sep_fin || close_fin;
  assign fin_ok    = (phase_r != PhDrain) && (step_err == tilp_pkg::StOk) && fin_req
                     && (fin_err == tilp_pkg::StOk);
  assign pos_after = fin_ok ? fin_pos : pos_r;

  always_comb begin
    if (ph_i == PhSign) begin
      close_st = tilp_pkg::StMalformed;
    end else if (close_fin && (fin_err != tilp_pkg::StOk)) begin
      close_st = fin_err;
    end else if (pos_after != '0) begin
      close_st = tilp_pkg::StIncomplete;
    end else begin
      close_st = tilp_pkg::StOk;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    vcnt_nxt  = vcnt_r;
    res_v     = 1'b0;
    r_vv      = 1'b0;
    r_val     = '0;
    r_idx     = '0;
    r_done    = 1'b0;
    r_st      = tilp_pkg::StOk;
    r_tc      = '0;
    clr       = 1'b0;
    if (phase_r == PhDrain) begin
      if (in_end_only || in_is_last) begin
        clr = 1'b1;
      end
    end else if (step_err != tilp_pkg::StOk) begin
      res_v  = 1'b1;
      r_done = 1'b1;
      r_st   = step_err;
      clr    = 1'b1;
    end else begin
      phase_nxt = ph_i;
      mag_nxt   = mag_i;
      neg_nxt   = neg_i;
      if (fin_ok) begin
        pos_nxt   = fin_pos;
        vcnt_nxt  = vcnt_r + 1'b1;
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PhStart;
        res_v     = 1'b1;
        r_vv      = 1'b1;
        r_val     = fin_value;
        r_idx     = vcnt_r;
      end
      if (closing) begin
        res_v  = 1'b1;
        r_done = 1'b1;
        r_st   = close_st;
        r_tc   = (close_st == tilp_pkg::StOk) ? tc_count : '0;
        clr    = 1'b1;
      end
    end
    if (clr) begin
      mag_nxt  = '0;
      neg_nxt  = 1'b0;
      pos_nxt  = '0;
      vcnt_nxt = '0;
      if ((phase_r != PhDrain) && (step_err != tilp_pkg::StOk) && !in_is_last) begin
        phase_nxt = PhDrain;
      end else begin
        phase_nxt = PhStart;
      end
    end
  end

  assign tc_ctrl.inc = in_fire && fin_ok;
  assign tc_ctrl.clr = in_fire && clr;
  assign tc_ctrl.sel = PosW'(eff_ar - 1'b1);

  tilp_tuple_cnt u_tuple_cnt (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (tc_ctrl),
    .tuple_count (tc_count)
  );

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = res_v;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r     <= ArW'(1);
      maxv_r      <= '1;
      phase_r     <= PhStart;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      pos_r       <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          tilp_pkg::RegArity:     arity_r <= pwdata[ArW-1:0];
          tilp_pkg::RegMaxValues: maxv_r  <= pwdata[CntW-1:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_nxt;
        mag_r   <= mag_nxt;
        neg_r   <= neg_nxt;
        pos_r   <= pos_nxt;
        vcnt_r  <= vcnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_v) begin
      vv_r   <= r_vv;
      val_r  <= r_val;
      idx_r  <= r_idx;
      done_r <= r_done;
      st_r   <= r_st;
      tc_r   <= r_tc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_valid = vv_r;
  assign out_value       = val_r;
  assign out_value_index = idx_r;
  assign out_done_res    = done_r;
  assign out_status      = st_r;
  assign out_tuple_count = tc_r;

endmodule

/* bench/tb_tuple_integer_list_parser.sv */
`timescale 1ns / 1ps

module tb_tuple_integer_list_parser;

  typedef struct packed {
    logic              value_valid;
    logic [31:0]       value;
    logic [15:0]       index;
    logic              done;
    tilp_pkg::status_t status;
    logic [15:0]       tuples;
  } list_result_t;

  typedef enum logic [1:0] {PH_START, PH_SIGN, PH_DIGITS, PH_DRAIN} parse_phase_t;
  typedef enum {ROW_BYTE, ROW_ARITY, ROW_MAXV} row_kind_t;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_FIXED} chk_t;

  typedef struct {
    row_kind_t    kind;
    logic [15:0]  data;
    bit           last;
    bit           eo;
    chk_t         chk;
    list_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic in_is_last = 1'b0;
  logic in_end_only = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_value_valid;
  logic signed [31:0] out_value;
  logic [15:0] out_value_index;
  logic out_done_res;
  logic [2:0] out_status;
  logic [15:0] out_tuple_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  tuple_integer_list_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .in_is_last(in_is_last), .in_end_only(in_end_only),
    .out_valid(out_valid), .out_ready(out_ready), .out_value_valid(out_value_valid),
    .out_value(out_value), .out_value_index(out_value_index),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_tuple_count(out_tuple_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [4:0]   reg_arity;
  logic [15:0]  reg_max_values;
  logic [30:0]  acc_mag;
  logic         acc_neg;
  parse_phase_t parse_ph;
  logic [3:0]   tup_pos;
  logic [15:0]  stored_cnt;
  list_result_t pred_res;

  list_result_t result_q[$];
  dir_row_t     dir_rows[$];
  logic [7:0]   list_text[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_values = 0;
  int n_ends = 0;
  int n_fails = 0;
  int n_cfg = 0;
  int n_err = 0;

  function automatic int unsigned eff_arity();
    if (reg_arity == 5'd0) return 1;
    if (reg_arity > 5'd16) return 16;
    return reg_arity;
  endfunction

  function automatic void clear_parse();
    acc_mag = '0;
    acc_neg = 1'b0;
    parse_ph = PH_START;
    tup_pos = '0;
    stored_cnt = '0;
  endfunction

  function automatic tilp_pkg::status_t close_value(bit has_sep, logic [7:0] sep);
    int unsigned t;
    t = tup_pos + 1;
    if (t >= eff_arity()) t = 0;
    tup_pos = t[3:0];
    if (stored_cnt >= reg_max_values) return tilp_pkg::StTooMany;
    if (has_sep && sep != ((t != 0) ? tilp_pkg::ChUnder : tilp_pkg::ChComma))
      return tilp_pkg::StMalformed;
    pred_res.value_valid = 1'b1;
    pred_res.value = acc_neg ? 32'd0 - {1'b0, acc_mag} : {1'b0, acc_mag};
    pred_res.index = stored_cnt;
    stored_cnt = stored_cnt + 16'd1;
    acc_mag = '0;
    acc_neg = 1'b0;
    parse_ph = PH_START;
    return tilp_pkg::StOk;
  endfunction

  function automatic void close_list();
    tilp_pkg::status_t st;
    if (parse_ph == PH_SIGN) begin
      st = tilp_pkg::StMalformed;
    end else begin
      st = tilp_pkg::StOk;
      if (parse_ph == PH_DIGITS) st = close_value(1'b0, 8'h00);
      if (st == tilp_pkg::StOk && tup_pos != 0) st = tilp_pkg::StIncomplete;
    end
    pred_res.done = 1'b1;
    pred_res.status = st;
    pred_res.tuples = (st == tilp_pkg::StOk) ? 16'(stored_cnt / eff_arity()) : 16'd0;
    clear_parse();
  endfunction

  // returns 1 when the byte produces a result, left in pred_res
  function automatic bit parse_step(logic [7:0] b, bit last, bit eo);
    tilp_pkg::status_t err;
    bit is_dig;
    logic [63:0] nm;
    err = tilp_pkg::StOk;
    pred_res = '0;
    if (parse_ph == PH_DRAIN) begin
      if (eo || last) clear_parse();
      return 1'b0;
    end
    if (eo) begin
      close_list();
      return 1'b1;
    end
    is_dig = (b >= tilp_pkg::ChZero) && (b <= tilp_pkg::ChNine);
    case (parse_ph)
      PH_START: begin
        if (b == tilp_pkg::ChMinus) begin
          acc_neg = 1'b1;
          parse_ph = PH_SIGN;
        end else if (is_dig) begin
          acc_mag = 31'(b - tilp_pkg::ChZero);
          parse_ph = PH_DIGITS;
        end else begin
          err = tilp_pkg::StMalformed;
        end
      end
      PH_SIGN: begin
        if (is_dig) begin
          acc_mag = 31'(b - tilp_pkg::ChZero);
          parse_ph = PH_DIGITS;
        end else begin
          err = tilp_pkg::StMalformed;
        end
      end
      default: begin
        if (is_dig) begin
          if (acc_mag > tilp_pkg::MagMax / 10) begin
            err = tilp_pkg::StOverflow;
          end else begin
            nm = 64'(acc_mag) * 64'd10 + 64'(b - tilp_pkg::ChZero);
            if (nm > 64'(tilp_pkg::MagMax)) err = tilp_pkg::StOverflow;
            else acc_mag = nm[30:0];
          end
        end else begin
          err = close_value(1'b1, b);
        end
      end
    endcase
    if (err != tilp_pkg::StOk) begin
      pred_res = '0;
      pred_res.done = 1'b1;
      pred_res.status = err;
      clear_parse();
      if (!last) parse_ph = PH_DRAIN;
      return 1'b1;
    end
    if (last) begin
      close_list();
      return 1'b1;
    end
    return pred_res.value_valid;
  endfunction

  function automatic list_result_t fin(tilp_pkg::status_t st, logic [15:0] tc);
    list_result_t r;
    r = '0;
    r.done = 1'b1;
    r.status = st;
    r.tuples = tc;
    return r;
  endfunction

  task automatic row(row_kind_t k, logic [15:0] d, bit last, bit eo, chk_t c,
                     list_result_t r);
    dir_rows.push_back('{k, d, last, eo, c, r});
  endtask

  task automatic send_item(logic [7:0] b, bit last, bit eo, chk_t c, list_result_t fixed);
    bit got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_is_last <= last;
    in_end_only <= eo;
    got = parse_step(b, last, eo);
    if (c == CHK_MODEL && got) result_q.push_back(pred_res);
    if (c == CHK_FIXED) result_q.push_back(fixed);
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tilp_pkg::RegArity) reg_arity = data[4:0];
    else reg_max_values = data[15:0];
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic random_config();
    logic [31:0] a;
    logic [31:0] m;
    wait_idle();
    case ($urandom_range(0, 6))
      0: a = 1;
      1: a = 16;
      2: a = 0;
      3: a = 31;
      default: a = $urandom_range(2, 5);
    endcase
    case ($urandom_range(0, 5))
      0: m = 0;
      1, 2: m = $urandom_range(1, 6);
      3: m = $urandom_range(0, 65535);
      default: m = 65535;
    endcase
    reg_write(tilp_pkg::RegArity, a);
    reg_write(tilp_pkg::RegMaxValues, m);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) list_text.push_back(s[i]);
  endtask

  task automatic add_number();
    case ($urandom_range(0, 9))
      0: add_text("2147483647");
      1: add_text("-2147483647");
      2: add_text("2147483648");
      3: add_text("-0");
      4: repeat ($urandom_range(10, 11))
           list_text.push_back(tilp_pkg::ChZero + 8'($urandom_range(0, 9)));
      5: add_text("0");
      default: begin
        if ($urandom_range(0, 2) == 0) list_text.push_back(tilp_pkg::ChMinus);
        repeat ($urandom_range(1, 4))
          list_text.push_back(tilp_pkg::ChZero + 8'($urandom_range(0, 9)));
      end
    endcase
  endtask

  // mostly well-formed lists; a few short tuples, dangling signs and noise bytes
  task automatic send_list();
    int unsigned ea;
    int unsigned n_vals;
    int unsigned mid;
    bit by_end;
    bit chg;
    list_text.delete();
    ea = eff_arity();
    n_vals = $urandom_range(0, (ea > 4) ? 1 : 3) * ea;
    if (n_vals != 0 && $urandom_range(0, 7) == 0) n_vals--;
    for (int k = 0; k < n_vals; k++) begin
      add_number();
      if (k != n_vals - 1)
        list_text.push_back(((k + 1) % ea != 0) ? tilp_pkg::ChUnder : tilp_pkg::ChComma);
    end
    if (n_vals != 0 && $urandom_range(0, 5) == 0)
      list_text.push_back((n_vals % ea != 0) ? tilp_pkg::ChUnder : tilp_pkg::ChComma);
    if ($urandom_range(0, 9) == 0) list_text.push_back(tilp_pkg::ChMinus);
    foreach (list_text[k])
      if ($urandom_range(0, 39) == 0) list_text[k] = 8'($urandom_range(0, 255));
    by_end = (list_text.size() == 0) || ($urandom_range(0, 1) == 1);
    mid = list_text.size() / 2;
    chg = ($urandom_range(0, 9) == 0);
    foreach (list_text[k]) begin
      if (chg && k == mid && k != 0) begin
        wait_idle();
        reg_write(tilp_pkg::RegArity, $urandom_range(1, reg_arity));
      end
      send_item(list_text[k], !by_end && (k == list_text.size() - 1), 1'b0, CHK_MODEL, '0);
    end
    if (by_end)
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, CHK_MODEL, '0);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        n_err++;
        $error("unexpected result: value_valid %0b done %0b status %0d",
               out_value_valid, out_done_res, out_status);
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (want.value_valid) n_values++;
        if (want.done) begin
          n_ends++;
          if (want.status != tilp_pkg::StOk) n_fails++;
        end
        if (out_value_valid !== want.value_valid) begin
          n_err++;
          $error("value_valid: expected %0b, got %0b", want.value_valid, out_value_valid);
        end
        if (out_value !== want.value) begin
          n_err++;
          $error("value: expected %0d, got %0d", $signed(want.value), out_value);
        end
        if (out_value_index !== want.index) begin
          n_err++;
          $error("value_index: expected %0d, got %0d", want.index, out_value_index);
        end
        if (out_done_res !== want.done) begin
          n_err++;
          $error("done_res: expected %0b, got %0b", want.done, out_done_res);
        end
        if (out_status !== want.status) begin
          n_err++;
          $error("status: expected %0d, got %0d", want.status, out_status);
        end
        if (out_tuple_count !== want.tuples) begin
          n_err++;
          $error("tuple_count: expected %0d, got %0d", want.tuples, out_tuple_count);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int base;
    string big_digits;
    reg_arity = 5'd1;
    reg_max_values = 16'hffff;
    clear_parse();
    big_digits = "214748364";

    row(ROW_BYTE, 16'h00, 1'b0, 1'b1, CHK_FIXED, fin(tilp_pkg::StOk, 16'd0));
    row(ROW_BYTE, 16'(tilp_pkg::ChZero), 1'b1, 1'b0, CHK_FIXED,
        '{1'b1, 32'd0, 16'd0, 1'b1, tilp_pkg::StOk, 16'd1});
    row(ROW_BYTE, 16'(tilp_pkg::ChMinus), 1'b1, 1'b0, CHK_FIXED,
        fin(tilp_pkg::StMalformed, 16'd0));
    row(ROW_BYTE, 16'h00, 1'b0, 1'b0, CHK_FIXED, fin(tilp_pkg::StMalformed, 16'd0));
    row(ROW_BYTE, 16'hff, 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("7"), 1'b1, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'(tilp_pkg::ChMinus), 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("x"), 1'b1, 1'b0, CHK_FIXED, fin(tilp_pkg::StMalformed, 16'd0));
    row(ROW_BYTE, 16'(tilp_pkg::ChMinus), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'("3"), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'(tilp_pkg::ChComma), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'("4"), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'(tilp_pkg::ChComma), 1'b1, 1'b0, CHK_MODEL, '0);
    row(ROW_ARITY, 16'd2, 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("1"), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'(tilp_pkg::ChComma), 1'b0, 1'b0, CHK_FIXED,
        fin(tilp_pkg::StMalformed, 16'd0));
    row(ROW_BYTE, 16'(tilp_pkg::ChComma), 1'b1, 1'b1, CHK_NONE, '0);
    row(ROW_BYTE, 16'(tilp_pkg::ChMinus), 1'b0, 1'b0, CHK_MODEL, '0);
    row(ROW_BYTE, 16'("1"), 1'b1, 1'b0, CHK_MODEL, '0);
    row(ROW_MAXV, 16'd0, 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("5"), 1'b1, 1'b0, CHK_FIXED, fin(tilp_pkg::StTooMany, 16'd0));
    row(ROW_MAXV, 16'hffff, 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_ARITY, 16'd0, 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("8"), 1'b1, 1'b0, CHK_MODEL, '0);
    row(ROW_ARITY, 16'd1, 1'b0, 1'b0, CHK_NONE, '0);
    foreach (big_digits[i]) row(ROW_BYTE, 16'(big_digits[i]), 1'b0, 1'b0, CHK_NONE, '0);
    row(ROW_BYTE, 16'("8"), 1'b1, 1'b0, CHK_FIXED, fin(tilp_pkg::StOverflow, 16'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 57;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_ARITY: begin
          wait_idle();
          reg_write(tilp_pkg::RegArity, 32'(dir_rows[i].data));
        end
        ROW_MAXV: begin
          wait_idle();
          reg_write(tilp_pkg::RegMaxValues, 32'(dir_rows[i].data));
        end
        default: send_item(dir_rows[i].data[7:0], dir_rows[i].last, dir_rows[i].eo,
                           dir_rows[i].chk, dir_rows[i].res);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 10 : 0;
      base = n_sent;
      random_config();
      while (n_sent < base + 235) begin
        if ($urandom_range(0, 3) == 0) random_config();
        send_list();
      end
    end

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("%0d requests sent over %0d register writes; %0d results checked",
             n_sent, n_cfg, n_checked);
    $display("%0d values, %0d list ends of which %0d with an error status",
             n_values, n_ends, n_fails);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
